### design/value_noise_bilinear_sampler_macros.svh
// Assertion macros used by the sampler's checker.
`ifndef VALUE_NOISE_BILINEAR_SAMPLER_MACROS_SVH
`define VALUE_NOISE_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define VNBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vnbs: same-cycle check failed");

// Next-cycle implication, checked only while reset is released.
`define VNBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vnbs: next-cycle check failed");

// Implication that is also checked across reset.
`define VNBS_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("vnbs: reset check failed");

`endif

### design/vnbs_pkg.sv
// ----------------------------------------------------------------------------
// vnbs_pkg
// Shared widths, constants and types of the bilinear value-noise sampler.
// ----------------------------------------------------------------------------
package vnbs_pkg;

    localparam int DATA_W        = 16;
    localparam int IDX_W         = 4;
    localparam int ADDR_W        = 2 * IDX_W;
    localparam int LATTICE_DEPTH = 1 << ADDR_W;
    localparam int COORD_W       = 32;
    localparam int SCALE_W       = 4;
    localparam int MAX_SCALE     = 15;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [SCALE_W-1:0] GRID_SCALE_RST  = SCALE_W'(2);
    localparam logic               WRAP_ENABLE_RST = 1'b0;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SCALE  = 2'd0,
        CFG_WRAP_ENABLE = 2'd1
    } t_cfg_reg;

    // Low and high corner index along one axis.
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_axis_cells;

endpackage

### design/value_noise_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// value_noise_bilinear_sampler
// Bilinear value-noise sampler over a 16x16 lattice, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     i_in_valid / o_in_stall        i_func, i_lattice_x/y/value,
//                                           i_coord_x, i_coord_y
//  output    o_out_valid / i_out_stall      o_noise_value
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One item per cycle unless a held output backs up; results leave stage 5.
//  Stages: capture, fold/scale/index, lattice read, y blends, x blend.
//  The four corner reads come from two copies of the lattice, two ports each.
//  A load writes the lattice in the read stage and leaves the pipe there.
//  Each stage holds only when the one after it is full and held; bubbles close.
//  Reset (synchronous, active low) empties the pipe and loads the config
//  defaults; the lattice itself is not cleared.
// ----------------------------------------------------------------------------
module value_noise_bilinear_sampler
    import vnbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input items
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic [IDX_W-1:0]          i_lattice_x,
    input  logic [IDX_W-1:0]          i_lattice_y,
    input  logic [DATA_W-1:0]         i_lattice_value,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [DATA_W-1:0]         o_noise_value,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic [SCALE_W-1:0] r_scale;
    logic               r_wrap;
    logic [SCALE_W-1:0] n_scale;

    // handshake chain
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

    // stage 1: captured beat
    logic                      r_s1_valid;
    logic                      r_s1_func;
    logic [ADDR_W-1:0]         r_s1_waddr;
    logic [DATA_W-1:0]         r_s1_wdata;
    logic signed [COORD_W-1:0] r_s1_coord_x;
    logic signed [COORD_W-1:0] r_s1_coord_y;

    // stage 2: indices and weights
    t_axis_cells          cells_x, cells_y;
    logic [FRAC_BITS-1:0] weight_x, weight_y;
    logic                 r_s2_valid;
    logic                 r_s2_func;
    logic [ADDR_W-1:0]    r_s2_waddr;
    logic [DATA_W-1:0]    r_s2_wdata;
    t_axis_cells          r_s2_cells_x, r_s2_cells_y;
    logic [FRAC_BITS-1:0] r_s2_wx, r_s2_wy;

    // stage 3: corner values
    logic                 lat_we;
    logic [DATA_W-1:0]    v00, v01, v10, v11;
    logic                 r_s3_valid;
    logic [FRAC_BITS-1:0] r_s3_wx, r_s3_wy;

    // stage 4: blends along y
    logic [DATA_W-1:0]    blend_t1, blend_t2;
    logic                 r_s4_valid;
    logic [DATA_W-1:0]    r_s4_t1, r_s4_t2;
    logic [FRAC_BITS-1:0] r_s4_wx;

    // stage 5: output register
    logic [DATA_W-1:0] blend_out;
    logic              r_s5_valid;
    logic [DATA_W-1:0] r_s5_noise;

    // ------------------------------------------------------------------------
    // configuration registers; the scale is stored already saturated
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (i_cfg_data == CFG_DATA_W'(0)) begin
            n_scale = SCALE_W'(1);
        end else if (i_cfg_data > CFG_DATA_W'(MAX_SCALE)) begin
            n_scale = SCALE_W'(MAX_SCALE);
        end else begin
            n_scale = SCALE_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= GRID_SCALE_RST;
            r_wrap  <= WRAP_ENABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_SCALE:  r_scale <= n_scale;
                CFG_WRAP_ENABLE: r_wrap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage advance: a stage loads when it is empty or its beat moves on
    // ------------------------------------------------------------------------
    always_comb begin
        s5_rdy = !r_s5_valid || !i_out_stall;
        s4_rdy = !r_s4_valid || s5_rdy;
        s3_rdy = !r_s3_valid || s4_rdy;
        s2_rdy = !r_s2_valid || s3_rdy;
        s1_rdy = !r_s1_valid || s2_rdy;
    end

    assign o_in_stall = !s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_rdy) begin
                r_s2_valid <= r_s1_valid;
            end
            // drop loads here, they finish with the lattice write
            if (s3_rdy) begin
                r_s3_valid <= r_s2_valid && (r_s2_func == FUNC_SAMPLE);
            end
            if (s4_rdy) begin
                r_s4_valid <= r_s3_valid;
            end
            if (s5_rdy) begin
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_func    <= i_func;
            r_s1_waddr   <= {i_lattice_x, i_lattice_y};
            r_s1_wdata   <= i_lattice_value;
            r_s1_coord_x <= i_coord_x;
            r_s1_coord_y <= i_coord_y;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2
    // ------------------------------------------------------------------------
    vnbs_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .i_coord  (r_s1_coord_x),
        .i_scale  (r_scale),
        .i_wrap   (r_wrap),
        .o_cells  (cells_x),
        .o_weight (weight_x)
    );

    vnbs_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .i_coord  (r_s1_coord_y),
        .i_scale  (r_scale),
        .i_wrap   (r_wrap),
        .o_cells  (cells_y),
        .o_weight (weight_y)
    );

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_func    <= r_s1_func;
            r_s2_waddr   <= r_s1_waddr;
            r_s2_wdata   <= r_s1_wdata;
            r_s2_cells_x <= cells_x;
            r_s2_cells_y <= cells_y;
            r_s2_wx      <= weight_x;
            r_s2_wy      <= weight_y;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: both copies take every load; each serves one x column
    // ------------------------------------------------------------------------
    assign lat_we = r_s2_valid && (r_s2_func == FUNC_LOAD) && s3_rdy;

    vnbs_lattice u_lattice_lo (
        .i_clk    (i_clk),
        .i_we     (lat_we),
        .i_waddr  (r_s2_waddr),
        .i_wdata  (r_s2_wdata),
        .i_re     (s3_rdy),
        .i_raddr0 ({r_s2_cells_x.lo, r_s2_cells_y.lo}),
        .i_raddr1 ({r_s2_cells_x.lo, r_s2_cells_y.hi}),
        .o_rdata0 (v00),
        .o_rdata1 (v01)
    );

    vnbs_lattice u_lattice_hi (
        .i_clk    (i_clk),
        .i_we     (lat_we),
        .i_waddr  (r_s2_waddr),
        .i_wdata  (r_s2_wdata),
        .i_re     (s3_rdy),
        .i_raddr0 ({r_s2_cells_x.hi, r_s2_cells_y.lo}),
        .i_raddr1 ({r_s2_cells_x.hi, r_s2_cells_y.hi}),
        .o_rdata0 (v10),
        .o_rdata1 (v11)
    );

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_s3_wx <= r_s2_wx;
            r_s3_wy <= r_s2_wy;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4
    // ------------------------------------------------------------------------
    vnbs_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp_t1 (
        .i_a (v00),
        .i_b (v01),
        .i_t (r_s3_wy),
        .o_y (blend_t1)
    );

    vnbs_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp_t2 (
        .i_a (v10),
        .i_b (v11),
        .i_t (r_s3_wy),
        .o_y (blend_t2)
    );

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_s4_t1 <= blend_t1;
            r_s4_t2 <= blend_t2;
            r_s4_wx <= r_s3_wx;
        end
    end

    // ------------------------------------------------------------------------
    // stage 5
    // ------------------------------------------------------------------------
    vnbs_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp_out (
        .i_a (r_s4_t1),
        .i_b (r_s4_t2),
        .i_t (r_s4_wx),
        .o_y (blend_out)
    );

    always_ff @(posedge i_clk) begin
        if (s5_rdy) begin
            r_s5_noise <= blend_out;
        end
    end

    assign o_out_valid   = r_s5_valid;
    assign o_noise_value = r_s5_noise;

endmodule

### design/vnbs_axis.sv
// ----------------------------------------------------------------------------
// vnbs_axis
// Folds one Q16.16 coordinate into [0,1), scales it by the grid size and
// yields the two corner indices and the blend weight along that axis.
// ----------------------------------------------------------------------------
module vnbs_axis
    import vnbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic signed [COORD_W-1:0]   i_coord,
    input  logic        [SCALE_W-1:0]   i_scale,
    input  logic                        i_wrap,
    output t_axis_cells                 o_cells,
    output logic        [FRAC_BITS-1:0] o_weight
);

    localparam int Q_W = FRAC_BITS + 1;
    localparam int P_W = Q_W + SCALE_W;
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

    logic                 neg;
    logic [COORD_W-1:0]   neg_coord;
    logic [FRAC_BITS-1:0] frac;
    logic [Q_W-1:0]       pos;
    logic [P_W-1:0]       scaled;
    logic [IDX_W-1:0]     cell_idx;
    logic [IDX_W-1:0]     lo;
    logic [IDX_W:0]       hi_inc;
    logic [IDX_W-1:0]     hi_sat;

    always_comb begin
        neg       = i_coord[COORD_W-1];
        neg_coord = COORD_W'(0) - COORD_W'(i_coord);
        // truncating remainder keeps the sign, so take it from the magnitude
        frac      = neg ? neg_coord[FRAC_BITS-1:0] : i_coord[FRAC_BITS-1:0];
        pos       = neg ? (ONE - {1'b0, frac}) : (ONE + {1'b0, frac});
        scaled    = P_W'(pos) * P_W'(i_scale);
        cell_idx  = scaled[P_W-1:Q_W];
        lo        = (cell_idx > i_scale) ? i_scale : cell_idx;
        hi_inc    = {1'b0, lo} + (IDX_W+1)'(1);
        hi_sat    = (hi_inc > {1'b0, i_scale}) ? i_scale : hi_inc[IDX_W-1:0];
        o_cells.lo = lo;
        o_cells.hi = (i_wrap && (hi_sat == i_scale)) ? IDX_W'(0) : hi_sat;
        o_weight   = scaled[FRAC_BITS:1];
    end

endmodule

### design/vnbs_lattice.sv
// ----------------------------------------------------------------------------
// vnbs_lattice
// Lattice value memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module vnbs_lattice
    import vnbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [LATTICE_DEPTH];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while the consuming stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### design/vnbs_lerp.sv
// ----------------------------------------------------------------------------
// vnbs_lerp
// Rounded linear blend of two 16-bit values by a fractional weight.
// ----------------------------------------------------------------------------
module vnbs_lerp
    import vnbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic [DATA_W-1:0]    i_a,
    input  logic [DATA_W-1:0]    i_b,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic [DATA_W-1:0]    o_y
);

    localparam int PROD_W = DATA_W + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W:0]    diff;
    logic signed [FRAC_BITS:0] tw;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  base;
    logic signed [PROD_W-1:0]  sum;

    // a*(1-t) + b*t is rewritten as a + (b-a)*t: one multiplier, same result
    always_comb begin
        diff = $signed({1'b0, i_b}) - $signed({1'b0, i_a});
        tw   = $signed({1'b0, i_t});
        prod = diff * tw;
        base = $signed({2'b00, i_a, {FRAC_BITS{1'b0}}});
        sum  = base + prod + HALF;
        o_y  = sum[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end

endmodule

### design/vnbs_checker.sv
// ----------------------------------------------------------------------------
// vnbs_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "value_noise_bilinear_sampler_macros.svh"

module vnbs_checker
    import vnbs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [DATA_W-1:0]         o_noise_value
);

    // a held result beat keeps its value
    `VNBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_noise_value))

    // the input side backs up only behind a held result, never on its own
    `VNBS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // reset empties the pipe
    `VNBS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n ##1 1'b1, !o_out_valid && !o_in_stall)

endmodule

bind value_noise_bilinear_sampler vnbs_checker u_vnbs_checker (.*);

### tb/value_noise_bilinear_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// value_noise_bilinear_sampler_tb
// Self-checking bench for the bilinear value-noise sampler.
// A queue of load and sample beats feeds a falling-edge driver. A rising-edge
// monitor predicts each sample from its own lattice copy and compares every
// result in order. Sample beats get loads in front of them for any corner the
// bench has not written yet. The run steps through several grid scale and
// wrap settings under varying input gaps and output stalls.
// ----------------------------------------------------------------------------
module value_noise_bilinear_sampler_tb;
    import vnbs_pkg::*;

    localparam int             NUM_PHASES     = 8;
    localparam int             PHASE_ITEMS    = 200;
    localparam int             PIPE_SETTLE    = 8;
    localparam int             WATCHDOG_LIMIT = 4000;
    localparam longint unsigned ONE_FX        = 64'd1 << FRAC_BITS_DEF;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        t_axis_cells        cells;
        logic [DATA_W-1:0]  wt;
    } t_axis_pos;

    typedef struct {
        logic               func;
        logic [IDX_W-1:0]   lx;
        logic [IDX_W-1:0]   ly;
        logic [DATA_W-1:0]  lval;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        bit                 drain;
    } t_noise_req;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_func = FUNC_LOAD;
    logic [IDX_W-1:0]          i_lattice_x = '0;
    logic [IDX_W-1:0]          i_lattice_y = '0;
    logic [DATA_W-1:0]         i_lattice_value = '0;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [DATA_W-1:0]         o_noise_value;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    t_noise_req        req_queue[$];
    logic [DATA_W-1:0] noise_due[$];
    logic [DATA_W-1:0] lattice_copy[LATTICE_DEPTH];
    bit                lattice_written[LATTICE_DEPTH];
    logic [SCALE_W-1:0] scale_reg = GRID_SCALE_RST;
    logic               wrap_reg = WRAP_ENABLE_RST;
    logic               in_beat_seen = 1'b0;
    int                 in_idle_pct = 0;
    int                 out_stall_pct = 0;
    int                 err_count = 0;
    int                 quiet_cycles = 0;

    value_noise_bilinear_sampler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_lattice_x     (i_lattice_x),
        .i_lattice_y     (i_lattice_y),
        .i_lattice_value (i_lattice_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_noise_value   (o_noise_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SCALE_W-1:0] live_scale(logic [SCALE_W-1:0] raw);
        if (raw == 0)
            return SCALE_W'(1);
        if (raw > MAX_SCALE)
            return SCALE_W'(MAX_SCALE);
        return raw;
    endfunction

    // Fold one coordinate into [0,1), scale it, and split into cells and weight.
    function automatic t_axis_pos locate(logic [COORD_W-1:0] c, logic [SCALE_W-1:0] s,
                                         logic wrap);
        logic [FRAC_BITS_DEF-1:0]   m;
        logic [FRAC_BITS_DEF+1:0]   q;
        logic [FRAC_BITS_DEF+5:0]   p;
        logic [IDX_W:0]             hi;
        t_axis_pos                  r;
        m = c[FRAC_BITS_DEF-1:0];
        if (c[COORD_W-1])
            m = '0 - c[FRAC_BITS_DEF-1:0];
        q = c[COORD_W-1] ? ((FRAC_BITS_DEF+2)'(ONE_FX) - m)
                         : ((FRAC_BITS_DEF+2)'(ONE_FX) + m);
        p = q * s;
        r.cells.lo = IDX_W'(p >> (FRAC_BITS_DEF + 1));
        hi = (IDX_W+1)'(r.cells.lo) + 1'b1;
        if (hi > {1'b0, s})
            hi = {1'b0, s};
        if (wrap && hi == {1'b0, s})
            hi = '0;
        r.cells.hi = hi[IDX_W-1:0];
        r.wt = p[FRAC_BITS_DEF:1];
        return r;
    endfunction

    // Round-to-nearest linear blend of a toward b by weight t.
    function automatic logic [DATA_W-1:0] blend(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                logic [DATA_W-1:0] t);
        longint unsigned acc;
        acc = 64'(a) * (ONE_FX - 64'(t)) + 64'(b) * 64'(t) + (ONE_FX >> 1);
        return DATA_W'(acc >> FRAC_BITS_DEF);
    endfunction

    function automatic logic [DATA_W-1:0] predict_noise(logic [COORD_W-1:0] cx,
                                                        logic [COORD_W-1:0] cy);
        logic [SCALE_W-1:0] s;
        t_axis_pos          ax;
        t_axis_pos          ay;
        logic [DATA_W-1:0]  near_col;
        logic [DATA_W-1:0]  far_col;
        s = live_scale(scale_reg);
        ax = locate(cx, s, wrap_reg);
        ay = locate(cy, s, wrap_reg);
        near_col = blend(lattice_copy[{ax.cells.lo, ay.cells.lo}],
                         lattice_copy[{ax.cells.lo, ay.cells.hi}], ay.wt);
        far_col = blend(lattice_copy[{ax.cells.hi, ay.cells.lo}],
                        lattice_copy[{ax.cells.hi, ay.cells.hi}], ay.wt);
        return blend(near_col, far_col, ax.wt);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] r;
        r = $urandom;
        case ($urandom_range(19))
            0:  r = 32'h8000_0000;
            1:  r = 32'h7FFF_FFFF;
            2:  r = 32'hFFFF_FFFF;
            3:  r = 32'h0000_0000;
            4:  r = 32'h0001_0000;
            5:  r = 32'hFFFF_0000;
            6:  r = 32'h0002_0000;
            7:  r = 32'hFFFE_0000;
            8:  r = 32'($urandom_range(32'h4_0000)) - 32'h2_0000;
            9:  r = {r[31:16], 16'h0000};
            10: r = {r[31:16], 16'hFFFF - 16'($urandom_range(3))};
            11: r = {r[31:16], 16'($urandom_range(3))};
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_load(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
                              logic [DATA_W-1:0] v);
        t_noise_req req;
        req.func  = FUNC_LOAD;
        req.lx    = x;
        req.ly    = y;
        req.lval  = v;
        req.cx    = $urandom;
        req.cy    = $urandom;
        req.drain = 1'b0;
        req_queue.push_back(req);
        lattice_written[{x, y}] = 1'b1;
    endtask

    task automatic claim_entry(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
        if (!lattice_written[{x, y}])
            queue_load(x, y, DATA_W'($urandom));
    endtask

    // Write any corner not yet loaded, then the sample itself.
    task automatic queue_sample(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, bit hold);
        logic [SCALE_W-1:0] s;
        t_axis_pos          ax;
        t_axis_pos          ay;
        t_noise_req         req;
        s = live_scale(scale_reg);
        ax = locate(cx, s, wrap_reg);
        ay = locate(cy, s, wrap_reg);
        claim_entry(ax.cells.lo, ay.cells.lo);
        claim_entry(ax.cells.lo, ay.cells.hi);
        claim_entry(ax.cells.hi, ay.cells.lo);
        claim_entry(ax.cells.hi, ay.cells.hi);
        req.func  = FUNC_SAMPLE;
        req.lx    = $urandom;
        req.ly    = $urandom;
        req.lval  = $urandom;
        req.cx    = cx;
        req.cy    = cy;
        req.drain = hold;
        req_queue.push_back(req);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_GRID_SCALE:  scale_reg = SCALE_W'(val);
            CFG_WRAP_ENABLE: wrap_reg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain everything, then give trailing loads time to leave the pipe.
    task automatic wait_quiet();
        while (req_queue.size() != 0 || i_in_valid || noise_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic flag_error(string why, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch (%s): expected %h, got %h", why, want, got);
    endtask

    always @(negedge i_clk) begin : driver
        t_noise_req req;
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_seen) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= in_idle_pct
                    && !(req_queue[0].drain && noise_due.size() != 0)) begin
                req = req_queue.pop_front();
                i_in_valid      <= 1'b1;
                i_func          <= req.func;
                i_lattice_x     <= req.lx;
                i_lattice_y     <= req.ly;
                i_lattice_value <= req.lval;
                i_coord_x       <= req.cx;
                i_coord_y       <= req.cy;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            in_beat_seen <= 1'b0;
        end else begin
            in_beat_seen <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                if (i_func == FUNC_SAMPLE)
                    noise_due.push_back(predict_noise(i_coord_x, i_coord_y));
                else
                    lattice_copy[{i_lattice_x, i_lattice_y}] = i_lattice_value;
            end
            if (o_out_valid && !i_out_stall) begin
                if (noise_due.size() == 0) begin
                    flag_error("unexpected beat", '0, o_noise_value);
                end else begin
                    want = noise_due.pop_front();
                    if (o_noise_value !== want)
                        flag_error("noise_value", want, o_noise_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [SCALE_W-1:0] s_val;
        logic               w_val;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset configuration.
        in_idle_pct   = 14;
        out_stall_pct = 77;
        queue_load(4'd0, 4'd0, 16'h0000);
        queue_load(4'd15, 4'd15, 16'hFFFF);
        queue_load(4'd0, 4'd15, 16'hFFFF);
        queue_load(4'd15, 4'd0, 16'h0000);
        queue_load(4'd1, 4'd1, 16'h8000);
        queue_load(4'd2, 4'd2, 16'h5A5A);
        queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
        queue_sample(32'hFFFF_0000, 32'h0002_0000, 1'b0);
        queue_sample(32'h0000_8000, 32'hFFFF_8000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h0000_C000, 32'hFFFF_4000, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin s_val = 4'd0;  w_val = 1'b0; end
                1: begin s_val = 4'd1;  w_val = 1'b1; end
                2: begin s_val = 4'd15; w_val = 1'b0; end
                3: begin s_val = 4'd15; w_val = 1'b1; end
                4: begin s_val = 4'd7;  w_val = 1'b1; end
                default: begin
                    s_val = SCALE_W'($urandom);
                    w_val = 1'($urandom);
                end
            endcase
            write_cfg(CFG_GRID_SCALE, CFG_DATA_W'(s_val));
            write_cfg(CFG_WRAP_ENABLE, CFG_DATA_W'(w_val));
            if (ph == 0) begin
                write_cfg(CFG_UNMAPPED_LO, CFG_DATA_W'($urandom));
                write_cfg(CFG_UNMAPPED_HI, CFG_DATA_W'($urandom));
            end
            in_idle_pct   = (ph < 3) ? 14 : (ph < 6) ? 77 : 0;
            out_stall_pct = (ph < 3) ? 77 : (ph < 6) ? 14 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(3) == 0 && !(ph == 0 && n == 50))
                    queue_load(IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
                else
                    queue_sample(pick_coord(), pick_coord(),
                                 (ph == 0 && n == 50) || $urandom_range(149) == 0);
            end
            wait_quiet();
        end

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/vnbs_pkg.sv
design/vnbs_axis.sv
design/vnbs_lattice.sv
design/vnbs_lerp.sv
design/value_noise_bilinear_sampler.sv
design/vnbs_checker.sv
tb/value_noise_bilinear_sampler_tb.sv
